/* hdl/ptt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg: shared types, codes and port list matching for the trigger table
// Holds the request and verdict codes, the register indexes, the register
// bundle, the entry word layout and the port list scan.
// ----------------------------------------------------------------------------
package ptt_pkg;

   // table geometry
   localparam int PTT_ENTRY_SLOTS = 4;
   localparam int PTT_PORT_SLOTS  = 4;
   localparam int PTT_LIST_SLOTS  = 4;
   localparam int PTT_LIST_W      = 16 * PTT_LIST_SLOTS;

   localparam logic [15:0] PTT_PORT_END      = 16'hFFFF;
   localparam logic [23:0] PTT_TIMEOUT_RESET = 24'd600;

   // IP protocol numbers
   localparam logic [7:0] PROTO_ANY = 8'd0;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   // request modes
   localparam logic [1:0] MODE_TICK     = 2'd0;
   localparam logic [1:0] MODE_OUT      = 2'd1;
   localparam logic [1:0] MODE_IN       = 2'd2;
   localparam logic [1:0] MODE_REDIRECT = 2'd3;

   // verdicts
   localparam logic [1:0] VERDICT_CONTINUE = 2'd0;
   localparam logic [1:0] VERDICT_ACCEPT   = 2'd1;
   localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_TRIG_LIST  = 3'd0;
   localparam logic [2:0] CSR_TRIG_FLAGS = 3'd1;
   localparam logic [2:0] CSR_FWD_LIST   = 3'd2;
   localparam logic [2:0] CSR_FWD_FLAGS  = 3'd3;
   localparam logic [2:0] CSR_TRIG_PROTO = 3'd4;
   localparam logic [2:0] CSR_FWD_PROTO  = 3'd5;
   localparam logic [2:0] CSR_TIMEOUT    = 3'd6;

   typedef struct packed {
      logic [PTT_LIST_W-1:0]     trig_list;
      logic [PTT_LIST_SLOTS-1:0] trig_flags;
      logic [PTT_LIST_W-1:0]     fwd_list;
      logic [PTT_LIST_SLOTS-1:0] fwd_flags;
      logic [7:0]                trig_proto;
      logic [7:0]                fwd_proto;
      logic [23:0]               timeout;
   } ptt_cfg_type;

   typedef struct packed {
      logic trig_hit;
      logic fwd_hit;
   } ptt_hits_type;

   typedef struct packed {
      logic        is_udp;
      logic [23:0] ticks;
      logic [31:0] addr;
   } ptt_entry_type;

   // Slots past the packed list read as the terminator value, flag clear.
   function automatic logic [15:0] slot_port(input logic [PTT_LIST_W-1:0] list,
                                             input int i);
      logic [15:0] s;
      s = PTT_PORT_END;
      if (i < PTT_LIST_SLOTS) begin
         s = list[i*16 +: 16];
      end
      return s;
   endfunction

   function automatic logic slot_flag(input logic [PTT_LIST_SLOTS-1:0] flags,
                                      input int i);
      logic f;
      f = 1'b0;
      if (i < PTT_LIST_SLOTS) begin
         f = flags[i];
      end
      return f;
   endfunction

   // Walk the slots: a flagged terminator ends the list, a flagged slot
   // spans up to the next slot and swallows it.
   function automatic logic ports_hit(input logic [PTT_LIST_W-1:0]     list,
                                      input logic [PTT_LIST_SLOTS-1:0] flags,
                                      input logic [15:0]               port);
      logic        hit;
      logic        stop;
      logic        skip;
      logic        f;
      logic [15:0] s;
      logic [15:0] e;
      hit  = 1'b0;
      stop = 1'b0;
      skip = 1'b0;
      for (int i = 0; i < PTT_PORT_SLOTS; i++) begin
         s = slot_port(list, i);
         f = slot_flag(flags, i);
         e = s;
         if (skip) begin
            skip = 1'b0;
         end else if (!stop && !hit) begin
            if (f && s == PTT_PORT_END) begin
               stop = 1'b1;
            end else begin
               if (f && (i + 1 < PTT_PORT_SLOTS)) begin
                  e    = slot_port(list, i + 1);
                  skip = 1'b1;
               end
               if (port >= s && port <= e) begin
                  hit = 1'b1;
               end
            end
         end
      end
      return hit;
   endfunction

endpackage

/* hdl/port_trigger_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_trigger_table: NAT port triggering table
// Tracks live triggers newest first, refreshes or inserts them on outbound
// headers, accepts or redirects inbound headers, and ages them on ticks.
//
//   channel   ports                                handshake
//   request   req_mode/ip_proto/dst_port/src_addr  start high while busy low
//   response  rsp_verdict/new_dst_addr/insert_...  rsp_strobe, one cycle
//   config    csr_index/csr_wdata                  csr_write_en, no wait
//
// A request passes through the scan and done states before the next one
// can be taken; rsp_strobe is registered out of the done state. The scan
// reads up to ENTRY_SLOTS entries from the entry memory (one read and one
// write port), one per cycle: a tick reads every live entry, a header stops
// at its first match.
// Synchronous reset empties the table at once; no clearing pass.
// The response cannot be held off; it is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module port_trigger_table import ptt_pkg::*; #(
   parameter int ENTRY_SLOTS = PTT_ENTRY_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_ip_proto,
   input  logic [15:0] req_dst_port,
   input  logic [31:0] req_src_addr,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_verdict,
   output logic [31:0] rsp_new_dst_addr,
   output logic        rsp_insert_dropped,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   ptt_cfg_type  cfg;
   ptt_hits_type hits;
   logic         req_accept;

   assign req_accept = start && !busy;

   // configuration registers
   ptt_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // port list lookup on the accepted request
   ptt_port_match u_port_match (
      .clock (clock),
      .load  (req_accept),
      .port  (req_dst_port),
      .cfg   (cfg),
      .hits  (hits)
   );

   // table memory and sequencer
   ptt_engine #(
      .ENTRY_SLOTS (ENTRY_SLOTS)
   ) u_engine (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_ip_proto       (req_ip_proto),
      .req_src_addr       (req_src_addr),
      .cfg                (cfg),
      .hits               (hits),
      .rsp_strobe         (rsp_strobe),
      .rsp_verdict        (rsp_verdict),
      .rsp_new_dst_addr   (rsp_new_dst_addr),
      .rsp_insert_dropped (rsp_insert_dropped)
   );

endmodule

/* hdl/ptt_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_csr: configuration registers
// Write-only register file; an index past the last register is ignored.
// ----------------------------------------------------------------------------
module ptt_csr import ptt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output ptt_cfg_type cfg
);

   ptt_cfg_type cfg_ff;
   ptt_cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_TRIG_LIST:  cfg_in.trig_list  = csr_wdata[PTT_LIST_W-1:0];
            CSR_TRIG_FLAGS: cfg_in.trig_flags = csr_wdata[PTT_LIST_SLOTS-1:0];
            CSR_FWD_LIST:   cfg_in.fwd_list   = csr_wdata[PTT_LIST_W-1:0];
            CSR_FWD_FLAGS:  cfg_in.fwd_flags  = csr_wdata[PTT_LIST_SLOTS-1:0];
            CSR_TRIG_PROTO: cfg_in.trig_proto = csr_wdata[7:0];
            CSR_FWD_PROTO:  cfg_in.fwd_proto  = csr_wdata[7:0];
            CSR_TIMEOUT:    cfg_in.timeout    = csr_wdata[23:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{trig_list:  '0,
                     trig_flags: '0,
                     fwd_list:   '0,
                     fwd_flags:  '0,
                     trig_proto: PROTO_ANY,
                     fwd_proto:  PROTO_ANY,
                     timeout:    PTT_TIMEOUT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/ptt_port_match.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_port_match: trigger and forward port list lookup
// Matches the destination port of an accepted request against both port
// lists and holds the two hit flags for the rest of the request.
// ----------------------------------------------------------------------------
module ptt_port_match import ptt_pkg::*; (
   input  logic         clock,
   input  logic         load,
   input  logic [15:0]  port,
   input  ptt_cfg_type  cfg,
   output ptt_hits_type hits
);

   ptt_hits_type hits_ff;
   ptt_hits_type hits_in;

   // scan both lists
   always_comb begin
      hits_in.trig_hit = ports_hit(cfg.trig_list, cfg.trig_flags, port);
      hits_in.fwd_hit  = ports_hit(cfg.fwd_list, cfg.fwd_flags, port);
   end

   // hold the flags while the request is worked on
   always_ff @(posedge clock) begin
      if (load) begin
         hits_ff <= hits_in;
      end
   end

   assign hits = hits_ff;

endmodule

/* hdl/ptt_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_engine: entry memory and request sequencer
// Walks the newest-first order list, reads one entry per cycle from the
// entry memory, ages, refreshes or matches it, and inserts new triggers.
// ----------------------------------------------------------------------------
module ptt_engine import ptt_pkg::*; #(
   parameter int ENTRY_SLOTS = PTT_ENTRY_SLOTS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_mode,
   input  logic [7:0]   req_ip_proto,
   input  logic [31:0]  req_src_addr,
   input  ptt_cfg_type  cfg,
   input  ptt_hits_type hits,
   output logic         rsp_strobe,
   output logic [1:0]   rsp_verdict,
   output logic [31:0]  rsp_new_dst_addr,
   output logic         rsp_insert_dropped
);

   localparam int SW = $clog2(ENTRY_SLOTS);
   localparam int CW = $clog2(ENTRY_SLOTS + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRY_SLOTS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [1:0]             mode_ff;
   logic [7:0]             proto_ff;
   logic [31:0]            src_ff;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          keep_ff, keep_in;
   logic [CW-1:0]          live_ff, live_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [SW-1:0]          rd_slot_ff, rd_slot_in;
   logic [ENTRY_SLOTS-1:0] valid_ff, valid_in;
   logic [SW-1:0]          order_ff [ENTRY_SLOTS];
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]             rsp_verdict_ff, rsp_verdict_in;
   logic [31:0]            rsp_dst_ff, rsp_dst_in;
   logic                   rsp_drop_ff, rsp_drop_in;

   ptt_entry_type          mem [ENTRY_SLOTS];
   ptt_entry_type          rdata_ff;
   ptt_entry_type          mem_wdata;
   logic                   mem_we;
   logic [SW-1:0]          mem_waddr;
   logic [SW-1:0]          mem_raddr;

   logic                   accept;
   logic                   is_udp;
   logic                   l4_ok;
   logic                   trig_proto_ok;
   logic                   fwd_proto_ok;
   logic                   scan_en;
   logic                   match_now;
   logic                   issue_ok;
   logic                   ord_we;
   logic                   ord_shift;
   logic [SW-1:0]          free_slot;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // request classification
   assign is_udp        = (proto_ff == PROTO_UDP);
   assign l4_ok         = (proto_ff == PROTO_TCP) || (proto_ff == PROTO_UDP);
   assign trig_proto_ok = (cfg.trig_proto == PROTO_ANY) || (cfg.trig_proto == proto_ff);
   assign fwd_proto_ok  = (cfg.fwd_proto == PROTO_ANY) || (cfg.fwd_proto == proto_ff);

   always_comb begin
      case (mode_ff)
         MODE_TICK: scan_en = 1'b1;
         MODE_OUT:  scan_en = l4_ok && hits.trig_hit;
         default:   scan_en = l4_ok && fwd_proto_ok && hits.fwd_hit;
      endcase
   end

   // entry returned by the memory this cycle
   always_comb begin
      case (mode_ff)
         MODE_OUT:               match_now = rd_vld_ff && (rdata_ff.is_udp == is_udp);
         MODE_IN, MODE_REDIRECT: match_now = rd_vld_ff && (rdata_ff.addr != src_ff);
         default:                match_now = 1'b0;
      endcase
   end

   assign issue_ok  = (state_ff == ST_SCAN) && scan_en && !match_now && (idx_ff < live_ff);
   assign mem_raddr = order_ff[idx_ff[SW-1:0]];

   // lowest free slot for an insert
   always_comb begin
      free_slot = '0;
      for (int i = ENTRY_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SW'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      keep_in        = keep_ff;
      live_in        = live_ff;
      rd_vld_in      = 1'b0;
      rd_slot_in     = rd_slot_ff;
      valid_in       = valid_ff;
      rsp_strobe_in  = 1'b0;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_dst_in     = rsp_dst_ff;
      rsp_drop_in    = rsp_drop_ff;
      mem_we         = 1'b0;
      mem_waddr      = rd_slot_ff;
      mem_wdata      = rdata_ff;
      ord_we         = 1'b0;
      ord_shift      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in       = ST_SCAN;
               idx_in         = '0;
               keep_in        = '0;
               rsp_verdict_in = VERDICT_CONTINUE;
               rsp_dst_in     = '0;
               rsp_drop_in    = 1'b0;
            end
         end

         ST_SCAN: begin
            // issue the next read
            rd_vld_in = issue_ok;
            if (issue_ok) begin
               idx_in     = idx_ff + 1'b1;
               rd_slot_in = mem_raddr;
            end
            // act on the entry read last cycle
            if (rd_vld_ff) begin
               case (mode_ff)
                  MODE_TICK: begin
                     if (rdata_ff.ticks <= 24'd1) begin
                        valid_in[rd_slot_ff] = 1'b0;
                     end else begin
                        mem_we          = 1'b1;
                        mem_wdata.ticks = rdata_ff.ticks - 24'd1;
                        ord_we          = 1'b1;
                        keep_in         = keep_ff + 1'b1;
                     end
                  end
                  MODE_OUT: begin
                     if (match_now) begin
                        mem_we          = 1'b1;
                        mem_wdata.ticks = cfg.timeout;
                        mem_wdata.addr  = src_ff;
                        rsp_verdict_in  = VERDICT_ACCEPT;
                     end
                  end
                  MODE_IN: begin
                     if (match_now) begin
                        mem_we          = 1'b1;
                        mem_wdata.ticks = cfg.timeout;
                        rsp_verdict_in  = VERDICT_ACCEPT;
                     end
                  end
                  default: begin
                     if (match_now) begin
                        rsp_verdict_in = VERDICT_REDIRECT;
                        rsp_dst_in     = rdata_ff.addr;
                     end
                  end
               endcase
            end
            if (!issue_ok) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (mode_ff == MODE_TICK) begin
               live_in = keep_ff;
            end
            // insert a new trigger at the head when nothing refreshed
            if (mode_ff == MODE_OUT && l4_ok && rsp_verdict_ff == VERDICT_CONTINUE &&
                trig_proto_ok && hits.trig_hit) begin
               if (live_ff >= FULL_COUNT) begin
                  rsp_drop_in = 1'b1;
               end else begin
                  mem_we              = 1'b1;
                  mem_waddr           = free_slot;
                  mem_wdata.is_udp    = is_udp;
                  mem_wdata.ticks     = cfg.timeout;
                  mem_wdata.addr      = src_ff;
                  valid_in[free_slot] = 1'b1;
                  ord_shift           = 1'b1;
                  live_in             = live_ff + 1'b1;
               end
            end
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         live_ff       <= '0;
         valid_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         valid_ff      <= valid_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // request and scan payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         proto_ff <= req_ip_proto;
         src_ff   <= req_src_addr;
      end
      idx_ff         <= idx_in;
      keep_ff        <= keep_in;
      rd_slot_ff     <= rd_slot_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_dst_ff     <= rsp_dst_in;
      rsp_drop_ff    <= rsp_drop_in;
   end

   // order list: shift in at the head, or compact survivors after a tick
   always_ff @(posedge clock) begin
      if (ord_shift) begin
         order_ff[0] <= free_slot;
         for (int i = 1; i < ENTRY_SLOTS; i++) begin
            order_ff[i] <= order_ff[i-1];
         end
      end else if (ord_we) begin
         order_ff[keep_ff[SW-1:0]] <= rd_slot_ff;
      end
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_new_dst_addr   = rsp_dst_ff;
   assign rsp_insert_dropped = rsp_drop_ff;

   a_live_max: assert property (@(posedge clock) disable iff (reset)
      live_ff <= FULL_COUNT)
      else $error("live count above table size");

   a_live_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> $countones(valid_ff) == live_ff)
      else $error("live count disagrees with valid entries");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff) == ST_DONE)
      else $error("response strobe without a finished request");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mem_we && !ord_we && !ord_shift)
      else $error("table written while idle");

   a_redirect: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_verdict_ff == VERDICT_REDIRECT |-> mode_ff == MODE_REDIRECT)
      else $error("redirect outside dnat mode");

   a_dst_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_verdict_ff != VERDICT_REDIRECT |-> rsp_dst_ff == '0)
      else $error("redirect address set without redirect");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the port trigger table
// Drives packet headers and ticks through the start/busy request port and
// reprograms the port lists, protocols and lifetime between phases. A shadow
// of the trigger table predicts each verdict, which is checked field by field
// against the strobed response. The run opens with a directed set and then
// sends biased random headers under several register settings.
// ----------------------------------------------------------------------------
module testbench import ptt_pkg::*;;

   localparam int          CYCLE_LIMIT   = 300000;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          PHASE_ITEMS   = 216;
   localparam logic [2:0]  CSR_UNUSED    = 3'd7;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [31:0] new_dst_addr;
      logic        insert_dropped;
   } trigger_outcome_type;

   // Shadow trigger table: predicts the verdict of each accepted request
   // and holds the verdicts that are still owed by the block.
   class verdict_board;
      logic [63:0]         trig_list;
      logic [3:0]          trig_flags;
      logic [63:0]         fwd_list;
      logic [3:0]          fwd_flags;
      logic [7:0]          trig_proto;
      logic [7:0]          fwd_proto;
      logic [23:0]         lifetime;
      bit                  live[PTT_ENTRY_SLOTS];
      logic [31:0]         owner[PTT_ENTRY_SLOTS];
      bit                  udp[PTT_ENTRY_SLOTS];
      logic [23:0]         ticks_left[PTT_ENTRY_SLOTS];
      int                  recency[PTT_ENTRY_SLOTS];
      int                  live_total;
      trigger_outcome_type pending_verdicts[$];
      int unsigned         mismatches;

      function new();
         trig_list  = '0;
         trig_flags = '0;
         fwd_list   = '0;
         fwd_flags  = '0;
         trig_proto = PROTO_ANY;
         fwd_proto  = PROTO_ANY;
         lifetime   = PTT_TIMEOUT_RESET;
         for (int s = 0; s < PTT_ENTRY_SLOTS; s++) begin
            live[s]    = 1'b0;
            recency[s] = 0;
         end
         live_total = 0;
         mismatches = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [63:0] data);
         case (idx)
            CSR_TRIG_LIST:  trig_list  = data;
            CSR_TRIG_FLAGS: trig_flags = data[3:0];
            CSR_FWD_LIST:   fwd_list   = data;
            CSR_FWD_FLAGS:  fwd_flags  = data[3:0];
            CSR_TRIG_PROTO: trig_proto = data[7:0];
            CSR_FWD_PROTO:  fwd_proto  = data[7:0];
            CSR_TIMEOUT:    lifetime   = data[23:0];
            default: ;
         endcase
      endfunction

      // Scan the slots in order; a flagged slot spans to the next one, a
      // flagged terminator closes the list.
      function bit port_listed(logic [63:0] list, logic [3:0] flags, logic [15:0] port);
         int          i;
         logic [15:0] lo;
         logic [15:0] hi;
         bit          ranged;
         i = 0;
         while (i < PTT_PORT_SLOTS) begin
            lo     = (i < PTT_LIST_SLOTS) ? list[i*16 +: 16] : PTT_PORT_END;
            ranged = (i < PTT_LIST_SLOTS) && flags[i];
            hi     = lo;
            if (ranged && lo == PTT_PORT_END) begin
               return 1'b0;
            end
            if (ranged && i + 1 < PTT_PORT_SLOTS) begin
               i++;
               hi = (i < PTT_LIST_SLOTS) ? list[i*16 +: 16] : PTT_PORT_END;
            end
            if (port >= lo && port <= hi) begin
               return 1'b1;
            end
            i++;
         end
         return 1'b0;
      endfunction

      function void note_request(logic [1:0] mode, logic [7:0] proto, logic [15:0] port,
                                 logic [31:0] src);
         trigger_outcome_type res;
         bit                  is_udp;
         bit                  matched;
         bit                  proto_ok;
         bit                  port_ok;
         int                  slot;
         int                  free_slot;
         int                  k;
         res = '0;
         if (mode == MODE_TICK) begin
            // age every live entry, then squeeze the expired ones out of the order
            for (int s = 0; s < PTT_ENTRY_SLOTS; s++) begin
               if (live[s]) begin
                  if (ticks_left[s] <= 24'd1) begin
                     live[s] = 1'b0;
                  end else begin
                     ticks_left[s]--;
                  end
               end
            end
            k = 0;
            for (int j = 0; j < live_total; j++) begin
               if (live[recency[j]]) begin
                  recency[k] = recency[j];
                  k++;
               end
            end
            live_total = k;
         end else if (proto == PROTO_TCP || proto == PROTO_UDP) begin
            is_udp  = (proto == PROTO_UDP);
            matched = 1'b0;
            if (mode == MODE_OUT) begin
               // refresh the newest entry of the same protocol
               for (int j = 0; j < live_total && !matched; j++) begin
                  slot = recency[j];
                  if (live[slot] && udp[slot] == is_udp &&
                      port_listed(trig_list, trig_flags, port)) begin
                     ticks_left[slot] = lifetime;
                     owner[slot]      = src;
                     res.verdict      = VERDICT_ACCEPT;
                     matched          = 1'b1;
                  end
               end
               // otherwise insert a new trigger at the head
               if (!matched && (trig_proto == PROTO_ANY || trig_proto == proto) &&
                   port_listed(trig_list, trig_flags, port)) begin
                  free_slot = -1;
                  for (int s = PTT_ENTRY_SLOTS - 1; s >= 0; s--) begin
                     if (!live[s]) begin
                        free_slot = s;
                     end
                  end
                  if (live_total >= PTT_ENTRY_SLOTS || free_slot < 0) begin
                     res.insert_dropped = 1'b1;
                  end else begin
                     for (int j = live_total; j > 0; j--) begin
                        recency[j] = recency[j-1];
                     end
                     recency[0]            = free_slot;
                     live[free_slot]       = 1'b1;
                     owner[free_slot]      = src;
                     udp[free_slot]        = is_udp;
                     ticks_left[free_slot] = lifetime;
                     live_total++;
                  end
               end
            end else begin
               // inbound: first entry whose address differs from the source
               proto_ok = (fwd_proto == PROTO_ANY || fwd_proto == proto);
               port_ok  = port_listed(fwd_list, fwd_flags, port);
               for (int j = 0; j < live_total && !matched; j++) begin
                  slot = recency[j];
                  if (live[slot] && src != owner[slot] && proto_ok && port_ok) begin
                     if (mode == MODE_IN) begin
                        ticks_left[slot] = lifetime;
                        res.verdict      = VERDICT_ACCEPT;
                     end else begin
                        res.verdict      = VERDICT_REDIRECT;
                        res.new_dst_addr = owner[slot];
                     end
                     matched = 1'b1;
                  end
               end
            end
         end
         pending_verdicts.push_back(res);
      endfunction

      function void check_response(logic [1:0] verdict, logic [31:0] new_dst_addr,
                                   logic insert_dropped);
         trigger_outcome_type want;
         if (pending_verdicts.size() == 0) begin
            $error("response with no request pending: verdict %0d", verdict);
            mismatches++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, verdict);
            mismatches++;
         end
         if (new_dst_addr !== want.new_dst_addr) begin
            $error("new_dst_addr: expected %h, got %h", want.new_dst_addr, new_dst_addr);
            mismatches++;
         end
         if (insert_dropped !== want.insert_dropped) begin
            $error("insert_dropped: expected %0d, got %0d", want.insert_dropped,
                   insert_dropped);
            mismatches++;
         end
      endfunction

      function int unsigned failures();
         return mismatches + pending_verdicts.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = MODE_TICK;
   logic [7:0]  req_ip_proto = '0;
   logic [15:0] req_dst_port = '0;
   logic [31:0] req_src_addr = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_verdict;
   logic [31:0] rsp_new_dst_addr;
   logic        rsp_insert_dropped;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   verdict_board sb = new();
   bit           idle_enable = 1'b1;
   logic [31:0]  addr_pool[4];
   int           cycle_count = 0;

   port_trigger_table uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_ip_proto       (req_ip_proto),
      .req_dst_port       (req_dst_port),
      .req_src_addr       (req_src_addr),
      .rsp_strobe         (rsp_strobe),
      .rsp_verdict        (rsp_verdict),
      .rsp_new_dst_addr   (rsp_new_dst_addr),
      .rsp_insert_dropped (rsp_insert_dropped),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   // check every strobed response against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_response(rsp_verdict, rsp_new_dst_addr, rsp_insert_dropped);
      end
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Present one request, idling first at random; return at the accepting edge
   // with start still high.
   task automatic send_request(input logic [1:0] mode, input logic [7:0] proto,
                               input logic [15:0] port, input logic [31:0] src);
      int unsigned gap;
      gap = 0;
      if (idle_enable) begin
         while ($urandom_range(99) < 22) begin
            gap++;
         end
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_mode     <= mode;
      req_ip_proto <= proto;
      req_dst_port <= port;
      req_src_addr <= src;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      sb.note_request(mode, proto, port, src);
   endtask

   // hold off new requests until every verdict is back
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] random_ports();
      logic [63:0] list;
      int          pick;
      for (int k = 0; k < PTT_LIST_SLOTS; k++) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            list[k*16 +: 16] = PTT_PORT_END;
         end else if (pick < 65) begin
            list[k*16 +: 16] = 16'($urandom_range(3000));
         end else begin
            list[k*16 +: 16] = 16'($urandom);
         end
      end
      return list;
   endfunction

   function automatic logic [7:0] pick_proto();
      case ($urandom_range(3))
         0:       return PROTO_ANY;
         1:       return PROTO_TCP;
         2:       return PROTO_UDP;
         default: return 8'($urandom);
      endcase
   endfunction

   // Program every register for one phase; narrow registers get junk above
   // their width.
   task automatic load_settings(input int phase);
      logic [63:0] tl;
      logic [63:0] fl;
      logic [3:0]  tf;
      logic [3:0]  ff;
      logic [7:0]  tp;
      logic [7:0]  fp;
      logic [23:0] tmo;
      logic [63:0] junk;
      tl  = random_ports();
      fl  = random_ports();
      tf  = 4'($urandom);
      ff  = 4'($urandom);
      tp  = pick_proto();
      fp  = pick_proto();
      tmo = 24'($urandom_range(1, 12));
      case (phase)
         0: begin
            tl  = '0;
            fl  = '0;
            tf  = '0;
            ff  = '0;
            tp  = PROTO_ANY;
            fp  = PROTO_ANY;
            tmo = 24'd1;
         end
         3: tmo = '0;
         7: begin
            tl  = '1;
            fl  = '1;
            tf  = '0;
            ff  = '1;
            tp  = PROTO_ANY;
            fp  = 8'hFF;
            tmo = '1;
         end
         default: ;
      endcase
      junk = {$urandom, $urandom};
      csr_write(CSR_TRIG_LIST, tl);
      csr_write(CSR_TRIG_FLAGS, {junk[63:4], tf});
      csr_write(CSR_FWD_LIST, fl);
      csr_write(CSR_FWD_FLAGS, {junk[63:4], ff});
      csr_write(CSR_TRIG_PROTO, {junk[63:8], tp});
      csr_write(CSR_FWD_PROTO, {junk[63:8], fp});
      csr_write(CSR_TIMEOUT, {junk[63:24], tmo});
      if (phase == 5) begin
         csr_write(CSR_UNUSED, junk);
      end
   endtask

   // Headers biased toward the configured ports, a small address pool and
   // TCP/UDP, with ticks mixed in to age the table.
   task automatic random_requests(input int count);
      logic [1:0]  mode;
      logic [7:0]  proto;
      logic [15:0] port;
      logic [31:0] src;
      logic [63:0] list;
      int          pick;
      int          k;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            mode = MODE_TICK;
         end else if (pick < 50) begin
            mode = MODE_OUT;
         end else if (pick < 75) begin
            mode = MODE_IN;
         end else begin
            mode = MODE_REDIRECT;
         end
         pick = $urandom_range(99);
         if (pick < 45) begin
            proto = PROTO_TCP;
         end else if (pick < 90) begin
            proto = PROTO_UDP;
         end else begin
            proto = 8'($urandom);
         end
         list = (mode == MODE_OUT) ? sb.trig_list : sb.fwd_list;
         k    = $urandom_range(PTT_LIST_SLOTS - 1);
         port = list[k*16 +: 16];
         case ($urandom_range(9))
            0, 1:    port = port - 16'd1;
            2, 3:    port = port + 16'd1;
            4, 5, 6: port = 16'($urandom);
            default: ;
         endcase
         src = ($urandom_range(99) < 75) ? addr_pool[$urandom_range(3)] : $urandom;
         send_request(mode, proto, port, src);
      end
   endtask

   initial begin
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      addr_pool[2] = $urandom;
      addr_pool[3] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: only port 0 listed, any protocol
      send_request(MODE_IN,       PROTO_TCP, 16'd0,    32'h0A000001);
      send_request(MODE_OUT,      PROTO_TCP, 16'd0,    32'h0A000001);
      send_request(MODE_OUT,      PROTO_TCP, 16'd0,    32'hC0A80005);
      send_request(MODE_OUT,      PROTO_UDP, 16'd0,    32'hFFFFFFFF);
      send_request(MODE_OUT,      8'd1,      16'd0,    32'h00000000);
      send_request(MODE_OUT,      PROTO_TCP, 16'hFFFF, 32'h00000000);
      send_request(MODE_IN,       PROTO_TCP, 16'd0,    32'h00000000);
      send_request(MODE_REDIRECT, PROTO_UDP, 16'd0,    32'hFFFFFFFF);
      send_request(MODE_REDIRECT, PROTO_TCP, 16'd0,    32'h00000000);
      send_request(MODE_REDIRECT, PROTO_TCP, 16'd1,    32'h00000000);
      send_request(MODE_TICK,     8'hFF,     16'hFFFF, 32'hFFFFFFFF);
      drain();

      // ranges, a terminator, a flag on the last slot and a zero lifetime
      csr_write(CSR_TRIG_LIST,  {16'd7000, 16'hFFFF, 16'd2000, 16'd1000});
      csr_write(CSR_TRIG_FLAGS, 64'h9);
      csr_write(CSR_FWD_LIST,   {16'd300, 16'hFFFF, 16'd200, 16'd100});
      csr_write(CSR_FWD_FLAGS,  64'h5);
      csr_write(CSR_TRIG_PROTO, {56'd0, PROTO_UDP});
      csr_write(CSR_FWD_PROTO,  {56'd0, PROTO_TCP});
      csr_write(CSR_TIMEOUT,    64'd0);
      send_request(MODE_OUT,      PROTO_UDP, 16'd1500, 32'h0A0A0A0A);
      send_request(MODE_OUT,      PROTO_TCP, 16'd7000, 32'h0B0B0B0B);
      send_request(MODE_OUT,      PROTO_UDP, 16'hFFFF, 32'h0C0C0C0C);
      send_request(MODE_OUT,      PROTO_UDP, 16'd999,  32'h0D0D0D0D);
      send_request(MODE_OUT,      PROTO_UDP, 16'd2001, 32'h0D0D0D0D);
      send_request(MODE_IN,       PROTO_TCP, 16'd150,  32'h01020304);
      send_request(MODE_IN,       PROTO_TCP, 16'd300,  32'h01020304);
      send_request(MODE_REDIRECT, PROTO_UDP, 16'd200,  32'h01020304);
      send_request(MODE_TICK,     PROTO_TCP, 16'd0,    32'h0);
      send_request(MODE_OUT,      PROTO_TCP, 16'd1000, 32'h0B0B0B0B);
      send_request(MODE_OUT,      PROTO_UDP, 16'd2000, 32'h0C0C0C0C);
      send_request(MODE_TICK,     PROTO_UDP, 16'd0,    32'h0);

      // random phases, one setting each; phase 3 runs with no idling
      for (int phase = 0; phase < 8; phase++) begin
         drain();
         load_settings(phase);
         idle_enable = (phase != 3);
         random_requests(PHASE_ITEMS);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
